// ----- hw/rtl/x86enc_pkg.sv -----
// x86enc_pkg: shared types and constants for the x86-64 instruction encoder.
// Used by the front, queue, back and top level; depends on nothing.
package x86enc_pkg;

	localparam int MAX_BYTES       = 12;
	localparam int LEN_W           = 4;
	localparam int ENC_QUEUE_DEPTH = 2;

	// Instruction kinds, dense numbering
	typedef enum logic [5:0] {
		K_PUSH      = 6'd0,  K_POP       = 6'd1,  K_RET       = 6'd2,  K_LEAVE     = 6'd3,
		K_MOV_I64   = 6'd4,  K_MOV_RR    = 6'd5,  K_MOV_LD    = 6'd6,  K_MOV_ST    = 6'd7,
		K_MOV_LDRIP = 6'd8,  K_MOV_STRIP = 6'd9,  K_MOVSX8    = 6'd10, K_MOVZX8    = 6'd11,
		K_LEA       = 6'd12, K_LEA_RIP   = 6'd13, K_ADD_RR    = 6'd14, K_SUB_RR    = 6'd15,
		K_ADD_I8    = 6'd16, K_SUB_I8    = 6'd17, K_IMUL_RR   = 6'd18, K_AND_RR    = 6'd19,
		K_OR_RR     = 6'd20, K_XOR_RR    = 6'd21, K_NEG       = 6'd22, K_NOT       = 6'd23,
		K_SHL_CL    = 6'd24, K_SAR_CL    = 6'd25, K_SHL_I8    = 6'd26, K_CMP_RR    = 6'd27,
		K_CMP_I32   = 6'd28, K_TEST_RR   = 6'd29, K_SETCC     = 6'd30, K_MOVZX8_B  = 6'd31,
		K_JMP       = 6'd32, K_JCC       = 6'd33, K_CALL      = 6'd34, K_CALL_R    = 6'd35,
		K_PUSH_I32  = 6'd36, K_ADD_RSP   = 6'd37, K_XCHG      = 6'd38, K_IDIV      = 6'd39,
		K_MOV_MI32  = 6'd40
	} kind_t;

	// Prefix and escape bytes
	localparam logic [7:0] REX_W      = 8'h48;
	localparam logic [7:0] REX_B      = 8'h41;
	localparam logic [7:0] REX_PLAIN  = 8'h40;
	localparam logic [7:0] ESC_0F     = 8'h0F;
	localparam logic [7:0] MOD_DIRECT = 8'hC0;
	localparam logic [7:0] MOD_DISP8  = 8'h40;
	localparam logic [7:0] MOD_DISP32 = 8'h80;
	localparam logic [7:0] SIB_NONE   = 8'h24;

	// One encoded instruction, byte 0 first
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [LEN_W-1:0]          len;
	} enc_item_t;

endpackage

// ----- hw/rtl/x86enc_if.sv -----
// x86enc_if: valid/ready channel interfaces for requests and encoded bytes.
// Standalone; no package dependency.
interface x86enc_req_if;
	logic               valid;
	logic               ready;
	logic [5:0]         kind;
	logic [3:0]         reg_a;
	logic [3:0]         reg_b;
	logic [3:0]         cond;
	logic signed [31:0] disp;
	logic [63:0]        immediate;

	modport source (output valid, kind, reg_a, reg_b, cond, disp, immediate, input ready);
	modport sink (input valid, kind, reg_a, reg_b, cond, disp, immediate, output ready);
endinterface

interface x86enc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, out_byte, last, input ready);
	modport sink (input valid, out_byte, last, output ready);
endinterface

// ----- hw/rtl/x86enc_front.sv -----
// x86enc_front: accepts requests, picks prefix/opcode/ModRM/SIB/disp/imm
// fields and assembles the byte string into a stage register. Uses x86enc_pkg.
module x86enc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	x86enc_req_if.sink            req,
	output logic                  push,
	output x86enc_pkg::enc_item_t item,
	input  logic                  full
);
	import x86enc_pkg::*;

	logic [3:0]  a, b;
	logic [2:0]  a_lo, b_lo;
	logic [31:0] d;
	logic [63:0] imm;

	logic        rex_en, modrm_en, sib_en;
	logic [7:0]  rex_byte, op0, op1, modrm;
	logic [1:0]  op_n;
	logic [3:0]  disp_n, imm_n;
	logic [31:0] disp_seg;
	logic [63:0] imm_seg;

	// memory operand helper values
	logic        d_zero, d_small, i_small;
	logic [7:0]  mb_mod;
	logic        mb_sib;
	logic [3:0]  mb_disp_n;
	logic [2:0]  mb_reg;

	logic [95:0]      tail;
	logic [LEN_W-1:0] len;
	logic             take;
	logic             valid_s1;
	enc_item_t        item_s1;

	assign a    = req.reg_a;
	assign b    = req.reg_b;
	assign a_lo = a[2:0];
	assign b_lo = b[2:0];
	assign d    = req.disp;
	assign imm  = req.immediate;

	assign d_zero  = (d == 32'd0);
	assign d_small = (&d[31:7]) | ~(|d[31:7]);
	assign i_small = (&imm[31:7]) | ~(|imm[31:7]);

	// ModRM form for [base+disp]
	always_comb begin
		mb_reg = (req.kind == K_MOV_MI32) ? 3'd0 : a_lo;
		mb_sib = (b_lo == 3'd4);
		if (d_zero && b_lo != 3'd5) begin
			mb_mod    = {2'b00, mb_reg, b_lo};
			mb_disp_n = 4'd0;
		end else if (d_small) begin
			mb_mod    = MOD_DISP8 | {2'b00, mb_reg, b_lo};
			mb_disp_n = 4'd1;
		end else begin
			mb_mod    = MOD_DISP32 | {2'b00, mb_reg, b_lo};
			mb_disp_n = 4'd4;
		end
	end

	// field selection by kind
	always_comb begin
		rex_en   = 1'b0;
		rex_byte = REX_W | {5'd0, a[3], 1'b0, b[3]};
		op_n     = 2'd1;
		op0      = 8'h90;
		op1      = 8'h00;
		modrm_en = 1'b0;
		modrm    = MOD_DIRECT | {2'b00, a_lo, b_lo};
		sib_en   = 1'b0;
		disp_n   = 4'd0;
		imm_n    = 4'd0;
		case (req.kind)
			K_PUSH, K_POP: begin
				rex_en   = a[3];
				rex_byte = REX_B;
				op0      = ((req.kind == K_PUSH) ? 8'h50 : 8'h58) | {5'd0, a_lo};
			end
			K_RET:   op0 = 8'hC3;
			K_LEAVE: op0 = 8'hC9;
			K_MOV_I64: begin
				rex_en   = 1'b1;
				rex_byte = REX_W | {7'd0, a[3]};
				op0      = 8'hB8 | {5'd0, a_lo};
				imm_n    = 4'd8;
			end
			K_MOV_RR, K_ADD_RR, K_SUB_RR, K_AND_RR, K_OR_RR, K_XOR_RR, K_CMP_RR,
			K_TEST_RR, K_XCHG: begin
				rex_en   = 1'b1;
				modrm_en = 1'b1;
				case (req.kind)
					K_MOV_RR:  op0 = 8'h8B;
					K_ADD_RR:  op0 = 8'h03;
					K_SUB_RR:  op0 = 8'h2B;
					K_AND_RR:  op0 = 8'h23;
					K_OR_RR:   op0 = 8'h0B;
					K_XOR_RR:  op0 = 8'h33;
					K_CMP_RR:  op0 = 8'h3B;
					K_TEST_RR: op0 = 8'h85;
					default:   op0 = 8'h87;
				endcase
			end
			K_MOVSX8, K_MOVZX8, K_MOVZX8_B, K_IMUL_RR: begin
				rex_en   = 1'b1;
				modrm_en = 1'b1;
				op_n     = 2'd2;
				op0      = ESC_0F;
				case (req.kind)
					K_MOVSX8:  op1 = 8'hBE;
					K_IMUL_RR: op1 = 8'hAF;
					default:   op1 = 8'hB6;
				endcase
			end
			K_MOV_LD, K_MOV_ST, K_LEA, K_MOV_MI32: begin
				rex_en   = 1'b1;
				modrm_en = 1'b1;
				modrm    = mb_mod;
				sib_en   = mb_sib;
				disp_n   = mb_disp_n;
				case (req.kind)
					K_MOV_LD: op0 = 8'h8B;
					K_MOV_ST: op0 = 8'h89;
					K_LEA:    op0 = 8'h8D;
					default: begin
						op0      = 8'hC7;
						rex_byte = REX_W | {7'd0, b[3]};
						imm_n    = 4'd4;
					end
				endcase
			end
			K_MOV_LDRIP, K_MOV_STRIP, K_LEA_RIP: begin
				rex_en   = 1'b1;
				rex_byte = REX_W | {5'd0, a[3], 2'b00};
				modrm_en = 1'b1;
				modrm    = {2'b00, a_lo, 3'd5};
				disp_n   = 4'd4;
				case (req.kind)
					K_MOV_LDRIP: op0 = 8'h8B;
					K_MOV_STRIP: op0 = 8'h89;
					default:     op0 = 8'h8D;
				endcase
			end
			K_ADD_I8, K_SUB_I8, K_NEG, K_NOT, K_SHL_CL, K_SAR_CL, K_SHL_I8, K_CMP_I32,
			K_CALL_R, K_IDIV: begin
				// single register in r/m, opcode extension in reg field
				rex_en   = 1'b1;
				rex_byte = REX_W | {7'd0, a[3]};
				modrm_en = 1'b1;
				case (req.kind)
					K_ADD_I8: begin
						op0 = 8'h83; modrm = MOD_DIRECT | {5'd0, a_lo}; imm_n = 4'd1;
					end
					K_SUB_I8: begin
						op0 = 8'h83; modrm = MOD_DIRECT | {2'b00, 3'd5, a_lo}; imm_n = 4'd1;
					end
					K_NEG:    begin op0 = 8'hF7; modrm = MOD_DIRECT | {2'b00, 3'd3, a_lo}; end
					K_NOT:    begin op0 = 8'hF7; modrm = MOD_DIRECT | {2'b00, 3'd2, a_lo}; end
					K_SHL_CL: begin op0 = 8'hD3; modrm = MOD_DIRECT | {2'b00, 3'd4, a_lo}; end
					K_SAR_CL: begin op0 = 8'hD3; modrm = MOD_DIRECT | {2'b00, 3'd7, a_lo}; end
					K_SHL_I8: begin
						op0 = 8'hC1; modrm = MOD_DIRECT | {2'b00, 3'd4, a_lo}; imm_n = 4'd1;
					end
					K_CMP_I32: begin
						op0   = i_small ? 8'h83 : 8'h81;
						modrm = MOD_DIRECT | {2'b00, 3'd7, a_lo};
						imm_n = i_small ? 4'd1 : 4'd4;
					end
					K_CALL_R: begin op0 = 8'hFF; modrm = MOD_DIRECT | {2'b00, 3'd2, a_lo}; end
					default:  begin op0 = 8'hF7; modrm = MOD_DIRECT | {2'b00, 3'd7, a_lo}; end
				endcase
			end
			K_SETCC: begin
				// byte registers spl..dil need a REX even without extension bits
				rex_en   = a[3] | a[2];
				rex_byte = REX_PLAIN | {7'd0, a[3]};
				op_n     = 2'd2;
				op0      = ESC_0F;
				op1      = 8'h90 | {4'd0, req.cond};
				modrm_en = 1'b1;
				modrm    = MOD_DIRECT | {5'd0, a_lo};
			end
			K_JMP:  begin op0 = 8'hE9; disp_n = 4'd4; end
			K_CALL: begin op0 = 8'hE8; disp_n = 4'd4; end
			K_JCC: begin
				op_n   = 2'd2;
				op0    = ESC_0F;
				op1    = 8'h80 | {4'd0, req.cond};
				disp_n = 4'd4;
			end
			K_PUSH_I32: begin op0 = 8'h68; imm_n = 4'd4; end
			K_ADD_RSP: begin
				rex_en   = 1'b1;
				rex_byte = REX_W;
				op0      = 8'h81;
				modrm_en = 1'b1;
				modrm    = 8'hC4;
				imm_n    = 4'd4;
			end
			default: op_n = 2'd0;
		endcase
	end

	// displacement field, zero when the form carries none
	always_comb begin
		case (disp_n)
			4'd0:    disp_seg = '0;
			4'd1:    disp_seg = {24'd0, d[7:0]};
			default: disp_seg = d;
		endcase
	end

	always_comb begin
		case (imm_n)
			4'd1:    imm_seg = {56'd0, imm[7:0]};
			4'd4:    imm_seg = {32'd0, imm[31:0]};
			default: imm_seg = imm;
		endcase
	end

	// assemble from the back: each field shifts the tail up by its size
	always_comb begin
		tail = {32'd0, imm_seg};
		tail = (tail << {disp_n, 3'b000}) | {64'd0, disp_seg};
		if (sib_en)
			tail = {tail[87:0], SIB_NONE};
		if (modrm_en)
			tail = {tail[87:0], modrm};
		if (op_n == 2'd2)
			tail = {tail[87:0], op1};
		if (op_n != 2'd0)
			tail = {tail[87:0], op0};
		if (rex_en)
			tail = {tail[87:0], rex_byte};
		if (op_n == 2'd0)
			len = '0;
		else
			len = LEN_W'({3'd0, rex_en} + {2'd0, op_n} + {3'd0, modrm_en} + {3'd0, sib_en}
				+ disp_n + imm_n);
	end

	// stage register; unknown kinds produce no bytes and are dropped here
	assign req.ready = !valid_s1 || !full;
	assign take      = req.valid && req.ready;
	assign push      = valid_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= (len != '0);
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.bytes <= tail;
			item_s1.len   <= len;
		end
	end

	assign item = item_s1;

endmodule

// ----- hw/rtl/x86enc_queue.sv -----
// x86enc_queue: short FIFO of encoded instructions between front and back.
// Uses x86enc_pkg for the item type.
module x86enc_queue #(
	parameter int DEPTH = x86enc_pkg::ENC_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  x86enc_pkg::enc_item_t wr_item,
	output logic                  full,
	input  logic                  pop,
	output x86enc_pkg::enc_item_t head,
	output logic                  empty
);
	import x86enc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	enc_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

// ----- hw/rtl/x86enc_back.sv -----
// x86enc_back: walks the queue head one byte per cycle, while code.ready allows,
// into the output register and pops the entry after its last byte. Uses x86enc_pkg.
module x86enc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  x86enc_pkg::enc_item_t head,
	input  logic                  empty,
	output logic                  pop,
	x86enc_byte_if.source         code
);
	import x86enc_pkg::*;

	logic [LEN_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_q;
	logic             emit;
	logic             at_end;

	assign emit   = !empty && (!out_valid_q || code.ready);
	assign at_end = (idx_q == head.len - 1'b1);
	assign pop    = emit && at_end;

	// byte index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (emit) begin
			idx_q       <= at_end ? '0 : idx_q + 1'b1;
			out_valid_q <= 1'b1;
		end else if (code.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= head.bytes[idx_q];
			last_q     <= at_end;
		end
	end

	assign code.valid    = out_valid_q;
	assign code.out_byte = out_byte_q;
	assign code.last     = last_q;

endmodule

// ----- hw/rtl/x86_64_instruction_encoder.sv -----
// x86_64_instruction_encoder: top level, front encoder, queue and byte emitter.
// Uses x86enc_pkg, x86enc_if, x86enc_front, x86enc_queue, x86enc_back.
//
// Usage:
//   req  (sink): one instruction request per transfer: kind, reg_a, reg_b,
//        cond, disp, immediate. Kinds 41..63 are taken and produce nothing.
//   code (source): the machine code, one byte per transfer, last set on
//        the final byte of each instruction (1 to 12 bytes).
// Path: front stage register, then the queue, then the output register.
// Throughput: one byte per cycle from the single output register while
//   code.ready is high; requests are taken every cycle
//   while the queue between front and back has room (QUEUE_DEPTH entries
//   plus the front stage register).
// Reset: arst_n clears the stage valid, queue pointers and output valid;
//   nothing is in flight afterwards.
// Stall: when code.ready is low the current byte holds; the queue fills,
//   then req.ready drops until bytes drain again.
module x86_64_instruction_encoder #(
	parameter int QUEUE_DEPTH = x86enc_pkg::ENC_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	x86enc_req_if.sink    req,
	x86enc_byte_if.source code
);
	import x86enc_pkg::*;

	logic      push, full, pop, empty;
	enc_item_t front_item, head_item;

	x86enc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.push   (push),
		.item   (front_item),
		.full   (full)
	);

	x86enc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.full    (full),
		.pop     (pop),
		.head    (head_item),
		.empty   (empty)
	);

	x86enc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head_item),
		.empty  (empty),
		.pop    (pop),
		.code   (code)
	);

endmodule
